/* sv/stz_pkg.sv */
// Shared types, token kind codes and character helpers for the source tokenizer.
// No dependencies.
package stz_pkg;

    localparam int DEF_OFFSET_BITS = 24;
    localparam int DEF_LINE_BITS   = 16;
    localparam int VAL_BITS        = 63;
    localparam logic [VAL_BITS-1:0] VAL_MAX = {VAL_BITS{1'b1}};

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_NL      = 5'd1;
    localparam logic [4:0] K_SEMI    = 5'd2;
    localparam logic [4:0] K_NUM     = 5'd3;
    localparam logic [4:0] K_LDEF    = 5'd4;
    localparam logic [4:0] K_LREF    = 5'd5;
    localparam logic [4:0] K_DIR     = 5'd6;
    localparam logic [4:0] K_DOT     = 5'd7;
    localparam logic [4:0] K_IDENT   = 5'd8;
    localparam logic [4:0] K_COLON   = 5'd9;
    localparam logic [4:0] K_COMMA   = 5'd10;
    localparam logic [4:0] K_LPAREN  = 5'd11;
    localparam logic [4:0] K_RPAREN  = 5'd12;
    localparam logic [4:0] K_STAR    = 5'd13;
    localparam logic [4:0] K_HASH    = 5'd14;
    localparam logic [4:0] K_SLASH   = 5'd15;
    localparam logic [4:0] K_PLUS    = 5'd16;
    localparam logic [4:0] K_MINUS   = 5'd17;
    localparam logic [4:0] K_EQUALS  = 5'd18;
    localparam logic [4:0] K_AT      = 5'd19;
    localparam logic [4:0] K_UNKNOWN = 5'd20;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_B     = 8'h62;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_HELD  = 8'b0000_0100,
        S_SLASH = 8'b0000_1000,
        S_HEX   = 8'b0001_0000,
        S_DOT   = 8'b0010_0000,
        S_DIR   = 8'b0100_0000,
        S_IDENT = 8'b1000_0000
    } t_scan;

    // queue push control: which of the two token slots carry a token
    typedef struct packed {
        logic a;
        logic b;
    } t_push;

    function automatic logic is_dig(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic id_start(input logic [7:0] c);
        return c == 8'h5F || is_alpha(c);
    endfunction

    function automatic logic id_cont(input logic [7:0] c);
        return id_start(c) || is_dig(c);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (is_dig(c))
            r = {1'b1, c[3:0]};
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h3A:   k = K_COLON;
            8'h2C:   k = K_COMMA;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h2A:   k = K_STAR;
            8'h23:   k = K_HASH;
            8'h2F:   k = K_SLASH;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h3D:   k = K_EQUALS;
            8'h40:   k = K_AT;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic ends_value(input logic [4:0] k);
        return k == K_NUM || k == K_RPAREN || k == K_LREF || k == K_DOT;
    endfunction

endpackage

/* sv/stz_if.sv */
// Source byte channel and token channel of the tokenizer.
// Depends on stz_pkg for default widths.
interface stz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_input;
    modport source (output valid, source_byte, end_of_input, input ready);
    modport sink   (input valid, source_byte, end_of_input, output ready);
endinterface

interface stz_out_if #(
    parameter int OFFSET_BITS = stz_pkg::DEF_OFFSET_BITS,
    parameter int LINE_BITS   = stz_pkg::DEF_LINE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             token_kind;
    logic [62:0]            number_value;
    logic                   hex_spelled;
    logic [3:0]             label_digit;
    logic                   label_forward;
    logic [LINE_BITS-1:0]   token_line;
    logic [LINE_BITS-1:0]   token_column;
    logic [OFFSET_BITS-1:0] token_offset;
    logic [OFFSET_BITS-1:0] token_length;
    logic                   last_of_run;
    modport source (output valid, token_kind, number_value, hex_spelled, label_digit,
                    label_forward, token_line, token_column, token_offset, token_length,
                    last_of_run, input ready);
    modport sink   (input valid, token_kind, number_value, hex_spelled, label_digit,
                    label_forward, token_line, token_column, token_offset, token_length,
                    last_of_run, output ready);
endinterface

/* sv/assembler_source_tokenizer.sv */
// Top level of the assembler source tokenizer: scanner state and token assembly.
// Depends on stz_pkg, stz_if (channels) and stz_queue (token queue).
//
// Takes one source byte per request and emits tokens (kind, value, label digit and
// direction, line, column, byte offset and raw length). All decisions for a byte are
// made combinationally from the registered scanner state, so a byte is accepted every
// cycle while the token queue has room for two more tokens. A byte yields zero, one
// or two tokens; the queue drains one token per cycle, so the sustained rate is one
// byte per cycle unless two-token bytes arrive back to back or the sink stalls.
// An end-of-input request flushes the pending token, emits EOF (last_of_run set)
// and returns the scanner to its reset state. Values saturate at 2^63-1, line and
// column at 2^LINE_BITS-1, offset and length at 2^OFFSET_BITS-1.
module assembler_source_tokenizer #(
    parameter int OFFSET_BITS = stz_pkg::DEF_OFFSET_BITS,
    parameter int LINE_BITS   = stz_pkg::DEF_LINE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stz_in_if.sink    i_src,
    stz_out_if.source o_tok
);
    import stz_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;
    localparam int W  = 5 + VAL_BITS + 1 + 4 + 1 + 2*LB + 2*OB;

    // scanner state
    t_scan         r_state, n_state;
    logic          r_cmt, n_cmt;
    logic [62:0]   r_acc, n_acc;
    logic          r_one, n_one;       // exactly one digit so far
    logic          r_fwd, n_fwd;       // held letter was 'f'
    logic [OB-1:0] r_soff, n_soff, r_hoff, n_hoff, r_coff, n_coff, r_len, n_len;
    logic [LB-1:0] r_sln, n_sln, r_scol, n_scol, r_hln, n_hln, r_hcol, n_hcol;
    logic [LB-1:0] r_cln, n_cln, r_ccol, n_ccol;
    logic          r_pval, n_pval;     // previous token ended in a value

    // token slots: A from the pending token, B from a fresh start or EOF
    logic          a_v, b_v;
    logic [4:0]    a_k, b_k;
    logic [62:0]   a_val;
    logic          a_hex, a_fwd;
    logic [3:0]    a_dig;
    logic [LB-1:0] a_ln, a_col, b_ln, b_col;
    logic [OB-1:0] a_off, a_len, b_off, b_len;

    logic          w_acc, w_room, do_idle;
    logic [7:0]    c;
    logic [66:0]   w_dec;
    logic [62:0]   w_dec_sat, w_hex_sat;
    logic [4:0]    w_hv;
    logic [W-1:0]  w_qout;
    t_push         w_push;

    function automatic logic [OB-1:0] inc_o(input logic [OB-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction
    function automatic logic [LB-1:0] inc_l(input logic [LB-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    assign c     = i_src.source_byte;
    assign i_src.ready = w_room;
    assign w_acc = i_src.valid && w_room;
    assign w_hv  = hex_val(c);
    assign w_dec = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {63'd0, c[3:0]};
    assign w_dec_sat = (w_dec > {4'd0, VAL_MAX}) ? VAL_MAX : w_dec[62:0];
    assign w_hex_sat = (r_acc[62:59] != 4'd0) ? VAL_MAX : {r_acc[58:0], w_hv[3:0]};

    always_comb begin
        n_state = r_state; n_cmt = r_cmt; n_acc = r_acc; n_one = r_one; n_fwd = r_fwd;
        n_soff = r_soff; n_sln = r_sln; n_scol = r_scol;
        n_hoff = r_hoff; n_hln = r_hln; n_hcol = r_hcol;
        n_coff = r_coff; n_cln = r_cln; n_ccol = r_ccol;
        n_len = r_len; n_pval = r_pval;
        a_v = 1'b0; a_k = K_EOF; a_val = '0; a_hex = 1'b0; a_dig = '0; a_fwd = 1'b0;
        a_ln = r_sln; a_col = r_scol; a_off = r_soff; a_len = r_len;
        b_v = 1'b0; b_k = K_EOF; b_ln = r_cln; b_col = r_ccol; b_off = r_coff; b_len = '0;
        do_idle = 1'b0;

        if (i_src.end_of_input) begin
            // complete the pending token as if nothing followed
            a_v = !r_cmt && r_state != S_IDLE;
            case (r_state)
                S_DEC:   begin a_k = K_NUM; a_val = r_acc; end
                S_HEX:   begin a_k = K_NUM; a_val = r_acc; a_hex = 1'b1; end
                S_HELD:  begin
                    a_k = K_LREF; a_dig = r_acc[3:0]; a_fwd = r_fwd;
                    a_len = OB'(2);
                end
                S_SLASH: a_k = K_SLASH;
                S_DOT:   a_k = K_DOT;
                S_DIR:   a_k = K_DIR;
                S_IDENT: a_k = K_IDENT;
                default: a_k = K_EOF;
            endcase
            b_v = 1'b1;
            n_state = S_IDLE; n_cmt = 1'b0; n_acc = '0; n_one = 1'b0; n_fwd = 1'b0;
            n_soff = '0; n_sln = LB'(1); n_scol = LB'(1);
            n_hoff = '0; n_hln = LB'(1); n_hcol = LB'(1);
            n_coff = '0; n_cln = LB'(1); n_ccol = LB'(1);
            n_len = '0; n_pval = 1'b0;
        end else begin
            if (r_cmt) begin
                if (c == CH_LF) begin
                    n_cmt = 1'b0;
                    do_idle = 1'b1;
                end
            end else begin
                case (r_state)
                    S_IDLE: do_idle = 1'b1;
                    S_DEC: begin
                        if (is_dig(c)) begin
                            n_acc = w_dec_sat; n_one = 1'b0; n_len = inc_o(r_len);
                        end else if (r_one && c == CH_COLON) begin
                            a_v = 1'b1; a_k = K_LDEF; a_dig = r_acc[3:0]; a_len = OB'(2);
                            n_state = S_IDLE;
                        end else if (r_one && (c == CH_F || c == CH_B)) begin
                            n_fwd = c == CH_F;
                            n_hoff = r_coff; n_hln = r_cln; n_hcol = r_ccol;
                            n_state = S_HELD;
                        end else begin
                            a_v = 1'b1; a_k = K_NUM; a_val = r_acc;
                            n_state = S_IDLE;
                            if (c == CH_DOT) a_len = inc_o(r_len);
                            else do_idle = 1'b1;
                        end
                    end
                    S_HELD: begin
                        a_v = 1'b1;
                        if (id_cont(c)) begin
                            // single-digit number, identifier starts at the letter
                            a_k = K_NUM; a_val = r_acc; a_len = OB'(1);
                            n_soff = r_hoff; n_sln = r_hln; n_scol = r_hcol;
                            n_len = OB'(2); n_state = S_IDENT;
                        end else begin
                            a_k = K_LREF; a_dig = r_acc[3:0]; a_fwd = r_fwd; a_len = OB'(2);
                            n_state = S_IDLE; do_idle = 1'b1;
                        end
                    end
                    S_SLASH: begin
                        if (w_hv[4]) begin
                            n_acc = {59'd0, w_hv[3:0]}; n_len = OB'(2); n_state = S_HEX;
                        end else begin
                            a_v = 1'b1; a_k = K_SLASH; a_len = OB'(1);
                            n_state = S_IDLE; do_idle = 1'b1;
                        end
                    end
                    S_HEX: begin
                        if (w_hv[4]) begin
                            n_acc = w_hex_sat; n_len = inc_o(r_len);
                        end else begin
                            a_v = 1'b1; a_k = K_NUM; a_val = r_acc; a_hex = 1'b1;
                            n_state = S_IDLE; do_idle = 1'b1;
                        end
                    end
                    S_DOT: begin
                        if (id_start(c)) begin
                            n_len = OB'(2); n_state = S_DIR;
                        end else begin
                            a_v = 1'b1; a_k = K_DOT; a_len = OB'(1);
                            n_state = S_IDLE; do_idle = 1'b1;
                        end
                    end
                    S_DIR, S_IDENT: begin
                        if (id_cont(c)) begin
                            n_len = inc_o(r_len);
                        end else begin
                            a_v = 1'b1; a_k = (r_state == S_DIR) ? K_DIR : K_IDENT;
                            n_state = S_IDLE; do_idle = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE; do_idle = 1'b1;
                    end
                endcase
            end

            if (do_idle) begin
                if (c == CH_BAR) begin
                    n_cmt = 1'b1;
                end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR)) begin
                    n_soff = r_coff; n_sln = r_cln; n_scol = r_ccol; n_len = OB'(1);
                    b_len = OB'(1);
                    if (c == CH_LF) begin
                        b_v = 1'b1; b_k = K_NL;
                    end else if (c == CH_SEMI) begin
                        b_v = 1'b1; b_k = K_SEMI;
                    end else if (is_dig(c)) begin
                        n_acc = {59'd0, c[3:0]}; n_one = 1'b1; n_state = S_DEC;
                    end else if (c == CH_SLASH && !(a_v ? ends_value(a_k) : r_pval)) begin
                        n_state = S_SLASH;
                    end else if (c == CH_DOT) begin
                        n_state = S_DOT;
                    end else if (id_start(c)) begin
                        n_state = S_IDENT;
                    end else begin
                        b_v = 1'b1; b_k = punct_kind(c);
                    end
                end
            end

            if (b_v) n_pval = ends_value(b_k);
            else if (a_v) n_pval = ends_value(a_k);

            if (c == CH_LF) begin
                n_cln = inc_l(r_cln); n_ccol = LB'(1);
            end else begin
                n_ccol = inc_l(r_ccol);
            end
            n_coff = inc_o(r_coff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cmt <= 1'b0; r_acc <= '0; r_one <= 1'b0; r_fwd <= 1'b0;
            r_soff <= '0; r_sln <= LB'(1); r_scol <= LB'(1);
            r_hoff <= '0; r_hln <= LB'(1); r_hcol <= LB'(1);
            r_coff <= '0; r_cln <= LB'(1); r_ccol <= LB'(1);
            r_len <= '0; r_pval <= 1'b0;
        end else if (w_acc) begin
            r_state <= n_state; r_cmt <= n_cmt; r_acc <= n_acc; r_one <= n_one;
            r_fwd <= n_fwd;
            r_soff <= n_soff; r_sln <= n_sln; r_scol <= n_scol;
            r_hoff <= n_hoff; r_hln <= n_hln; r_hcol <= n_hcol;
            r_coff <= n_coff; r_cln <= n_cln; r_ccol <= n_ccol;
            r_len <= n_len; r_pval <= n_pval;
        end
    end

    assign w_push.a = w_acc && a_v;
    assign w_push.b = w_acc && b_v;

    // entry: kind, value, hex, digit, forward, line, column, offset, length, last
    stz_queue #(.W(W + 1)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok_a ({a_k, a_val, a_hex, a_dig, a_fwd, a_ln, a_col, a_off, a_len, !b_v}),
        .i_tok_b ({b_k, 63'd0, 1'b0, 4'd0, 1'b0, b_ln, b_col, b_off, b_len, 1'b1}),
        .o_room2 (w_room),
        .o_valid (o_tok.valid),
        .i_ready (o_tok.ready),
        .o_tok   ({w_qout, o_tok.last_of_run})
    );

    assign {o_tok.token_kind, o_tok.number_value, o_tok.hex_spelled, o_tok.label_digit,
            o_tok.label_forward, o_tok.token_line, o_tok.token_column,
            o_tok.token_offset, o_tok.token_length} = w_qout;

    a_cmt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmt |-> r_state == S_IDLE) else $error("comment while token pending");
    a_eoi_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_src.end_of_input) |=> (r_state == S_IDLE && r_coff == '0))
        else $error("end of input did not reset scanner");
    a_one_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HELD |-> r_acc <= 63'd9) else $error("held label not one digit");

endmodule

/* sv/stz_queue.sv */
// Four-entry token queue taking up to two tokens per cycle, one out per cycle while i_ready is high.
// Depends on stz_pkg (t_push).
module stz_queue #(
    parameter int W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stz_pkg::t_push       i_push,
    input  logic [W-1:0]         i_tok_a,
    input  logic [W-1:0]         i_tok_b,
    output logic                 o_room2,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [W-1:0]         o_tok
);
    import stz_pkg::*;

    logic [W-1:0] r_mem [4];
    logic [2:0]   r_wp, r_rp;
    logic [2:0]   n_wp, n_rp;
    logic [2:0]   w_count;
    logic         w_pop;

    assign w_count = r_wp - r_rp;
    assign o_room2 = w_count <= 3'd2;
    assign o_valid = w_count != 3'd0;
    assign o_tok   = r_mem[r_rp[1:0]];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_rp = r_rp + {2'd0, w_pop};
        n_wp = r_wp + {2'd0, i_push.a} + {2'd0, i_push.b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
        if (i_push.a)
            r_mem[r_wp[1:0]] <= i_tok_a;
        if (i_push.b && i_push.a)
            r_mem[2'(r_wp[1:0] + 2'd1)] <= i_tok_b;
        else if (i_push.b)
            r_mem[r_wp[1:0]] <= i_tok_b;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= 3'd4) else $error("queue overfilled");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.a || i_push.b) |-> w_count <= 3'd2) else $error("push without room");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> r_rp == $past(r_rp) + 3'd1) else $error("read pointer slip");

endmodule
